// ===== rtl/bsm_pkg.sv =====
package bsm_pkg;

    // Field widths
    localparam int CMD_W      = 2;
    localparam int ADDR_W     = 16;
    localparam int DATA_W     = 8;
    localparam int MAP_W      = 19;
    localparam int MIRROR_W   = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 4;

    // Commands
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_PRG   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_CHR   = 2'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANKS_LOG2 = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_BANKS_LOG2 = 1'd1;

    localparam logic [2:0] PRG_LOG2_RESET = 3'd5;
    localparam logic [2:0] PRG_LOG2_MIN   = 3'd1;
    localparam logic [2:0] PRG_LOG2_MAX   = 3'd5;
    localparam logic [3:0] CHR_LOG2_RESET = 4'd8;
    localparam logic [3:0] CHR_LOG2_MAX   = 4'd9;

    // Register decode: upper address nibble
    localparam logic [3:0] HI_PRG_FIRST  = 4'h8;
    localparam logic [3:0] HI_MIRROR     = 4'h9;
    localparam logic [3:0] HI_PRG_SECOND = 4'hA;
    localparam logic [3:0] HI_CHR_FIRST  = 4'hB;
    localparam logic [3:0] HI_CHR_LAST   = 4'hE;
    localparam logic [3:0] HI_IRQ        = 4'hF;

    // Timer register offsets
    localparam logic [1:0] IRQ_LATCH_LO = 2'd0;
    localparam logic [1:0] IRQ_LATCH_HI = 2'd1;
    localparam logic [1:0] IRQ_CONTROL  = 2'd2;
    localparam logic [1:0] IRQ_ACK      = 2'd3;

    // Pattern slots and timer
    localparam int         CHR_SLOTS       = 8;
    localparam int         SLOT_W          = 3;
    localparam logic [8:0] PRESCALE_PERIOD = 9'd341;
    localparam logic [8:0] PRESCALE_STEP   = 9'd3;
    localparam logic [7:0] COUNT_TOP       = 8'hFF;

    typedef logic [8:0] chr_sel_t;

endpackage

// ===== rtl/bank_switch_mapper_with_irq_timer.sv =====
// Channel  | Ports                                                | Transfer when
// ---------+------------------------------------------------------+------------------------
// input    | s_valid, s_ready, s_command, s_address, s_write_data | s_valid && s_ready
// result   | m_valid, m_ready, m_irq_line, m_mapped_address,      | m_valid && m_ready
//          | m_nt_mirror                                          |
// config   | cfg_wr_en, cfg_index, cfg_wdata                      | cfg_wr_en
//
// One item per cycle sustained while the result side is ready; an input transfer
// loads the input register, and the result register loads from it when the input
// stage advances. All decode, timer and translate logic sits between those two
// registers. Reset is synchronous; there is no clearing pass. A stalled result
// register holds the input stage, and the input stage still takes a new transfer
// whenever it empties in the same cycle.
module bank_switch_mapper_with_irq_timer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [bsm_pkg::CMD_W-1:0]           s_command,
    input  logic [bsm_pkg::ADDR_W-1:0]          s_address,
    input  logic [bsm_pkg::DATA_W-1:0]          s_write_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_irq_line,
    output logic [bsm_pkg::MAP_W-1:0]           m_mapped_address,
    output logic [bsm_pkg::MIRROR_W-1:0]        m_nt_mirror,
    input  logic                                cfg_wr_en,
    input  logic [bsm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [bsm_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
    import bsm_pkg::*;

    // Input register
    logic                in_valid_reg, in_valid_next;
    logic [CMD_W-1:0]    in_cmd_reg;
    logic [ADDR_W-1:0]   in_addr_reg;
    logic [DATA_W-1:0]   in_data_reg;

    // Result register
    logic                out_valid_reg, out_valid_next;
    logic                out_irq_reg, out_irq_next;
    logic [MAP_W-1:0]    out_map_reg, out_map_next;
    logic [MIRROR_W-1:0] out_mirror_reg, out_mirror_next;

    // Configuration
    logic [2:0] prg_log2_reg;
    logic [3:0] chr_log2_reg;

    // Mapper state
    logic [4:0]     prg_first_reg, prg_first_next;
    logic [4:0]     prg_second_reg, prg_second_next;
    logic           prg_swap_reg, prg_swap_next;
    logic [1:0]     mirroring_reg, mirroring_next;
    chr_sel_t       chr_sel_reg [CHR_SLOTS];
    logic [7:0]     irq_reload_reg, irq_reload_next;
    logic [7:0]     irq_count_reg, irq_count_next;
    logic [8:0]     prescale_reg, prescale_next;
    logic           ack_enable_reg, ack_enable_next;
    logic           irq_enabled_reg, irq_enabled_next;
    logic           cycle_mode_reg, cycle_mode_next;
    logic           irq_pending_reg, irq_pending_next;

    // Decode and datapath
    logic              advance;
    logic              in_xfer;
    logic [3:0]        addr_hi;
    logic              addr_exact;
    logic [1:0]        addr_lo;
    logic              chr_wr;
    logic [SLOT_W-1:0] chr_wr_slot;
    logic [3:0]        chr_slot_hi;
    logic              counter_clk;
    logic [2:0]        prg_lg;
    logic [3:0]        chr_lg;
    logic [4:0]        prg_mask;
    logic [8:0]        chr_mask;
    logic [4:0]        prg_bank;
    chr_sel_t          chr_bank;

    // Drain the input stage whenever the result register is free or being taken.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign in_xfer = s_valid && s_ready;

    assign addr_hi    = in_addr_reg[15:12];
    assign addr_exact = (in_addr_reg[11:2] == 10'd0);
    assign addr_lo    = in_addr_reg[1:0];

    // Pattern slot: two slots per address nibble B..E, picked by address bit 1.
    assign chr_slot_hi = addr_hi - HI_CHR_FIRST;
    assign chr_wr_slot = {chr_slot_hi[1:0], addr_lo[1]};
    assign chr_wr = advance && (in_cmd_reg == CMD_WRITE) && addr_exact
                    && (addr_hi >= HI_CHR_FIRST) && (addr_hi <= HI_CHR_LAST);

    // Saturate bank-count registers on use.
    always_comb begin
        if (prg_log2_reg < PRG_LOG2_MIN) begin
            prg_lg = PRG_LOG2_MIN;
        end else if (prg_log2_reg > PRG_LOG2_MAX) begin
            prg_lg = PRG_LOG2_MAX;
        end else begin
            prg_lg = prg_log2_reg;
        end
        chr_lg = (chr_log2_reg > CHR_LOG2_MAX) ? CHR_LOG2_MAX : chr_log2_reg;
    end

    assign prg_mask = 5'((6'd1 << prg_lg) - 6'd1);
    assign chr_mask = 9'((10'd1 << chr_lg) - 10'd1);

    // Program window select; window 3 is always the last bank.
    always_comb begin
        case (in_addr_reg[14:13])
            2'd0:    prg_bank = prg_swap_reg ? (prg_mask - 5'd1) : prg_first_reg;
            2'd1:    prg_bank = prg_second_reg;
            2'd2:    prg_bank = prg_swap_reg ? prg_first_reg : (prg_mask - 5'd1);
            default: prg_bank = prg_mask;
        endcase
    end

    assign chr_bank = chr_sel_reg[in_addr_reg[12:10]] & chr_mask;

    always_comb begin
        prg_first_next   = prg_first_reg;
        prg_second_next  = prg_second_reg;
        prg_swap_next    = prg_swap_reg;
        mirroring_next   = mirroring_reg;
        irq_reload_next  = irq_reload_reg;
        irq_count_next   = irq_count_reg;
        prescale_next    = prescale_reg;
        ack_enable_next  = ack_enable_reg;
        irq_enabled_next = irq_enabled_reg;
        cycle_mode_next  = cycle_mode_reg;
        irq_pending_next = irq_pending_reg;
        counter_clk      = 1'b0;
        out_map_next     = '0;

        case (in_cmd_reg)
            CMD_WRITE: begin
                if (addr_exact) begin
                    case (addr_hi)
                        HI_PRG_FIRST:  prg_first_next = in_data_reg[4:0];
                        HI_MIRROR: begin
                            if (!addr_lo[1]) begin
                                mirroring_next = in_data_reg[1:0];
                            end else begin
                                prg_swap_next = in_data_reg[1];
                            end
                        end
                        HI_PRG_SECOND: prg_second_next = in_data_reg[4:0];
                        HI_IRQ: begin
                            // Any timer register write drops a pending interrupt.
                            irq_pending_next = 1'b0;
                            case (addr_lo)
                                IRQ_LATCH_LO: irq_reload_next = {irq_reload_reg[7:4],
                                                                 in_data_reg[3:0]};
                                IRQ_LATCH_HI: irq_reload_next = {in_data_reg[3:0],
                                                                 irq_reload_reg[3:0]};
                                IRQ_CONTROL: begin
                                    ack_enable_next  = in_data_reg[0];
                                    irq_enabled_next = in_data_reg[1];
                                    cycle_mode_next  = in_data_reg[2];
                                    if (in_data_reg[1]) begin
                                        irq_count_next = irq_reload_reg;
                                        prescale_next  = PRESCALE_PERIOD;
                                    end
                                end
                                IRQ_ACK:      irq_enabled_next = ack_enable_reg;
                                default:      irq_enabled_next = irq_enabled_reg;
                            endcase
                        end
                        default: prg_first_next = prg_first_reg;
                    endcase
                end
            end
            CMD_TICK: begin
                if (irq_enabled_reg) begin
                    if (cycle_mode_reg) begin
                        counter_clk = 1'b1;
                    end else if (prescale_reg <= PRESCALE_STEP) begin
                        prescale_next = prescale_reg - PRESCALE_STEP + PRESCALE_PERIOD;
                        counter_clk   = 1'b1;
                    end else begin
                        prescale_next = prescale_reg - PRESCALE_STEP;
                    end
                end
                if (counter_clk) begin
                    if (irq_count_reg == COUNT_TOP) begin
                        irq_count_next   = irq_reload_reg;
                        irq_pending_next = 1'b1;
                    end else begin
                        irq_count_next = irq_count_reg + 8'd1;
                    end
                end
            end
            CMD_PRG: begin
                if (in_addr_reg[15]) begin
                    out_map_next = {1'b0, prg_bank & prg_mask, in_addr_reg[12:0]};
                end
            end
            CMD_CHR: out_map_next = {chr_bank, in_addr_reg[9:0]};
            default: out_map_next = '0;
        endcase

        out_irq_next    = irq_pending_next;
        out_mirror_next = mirroring_next;
    end

    // Hold a waiting item until it moves on; take a new transfer in the same cycle.
    always_comb begin
        if (in_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    // Control and mapper state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            prg_log2_reg    <= PRG_LOG2_RESET;
            chr_log2_reg    <= CHR_LOG2_RESET;
            prg_first_reg   <= '0;
            prg_second_reg  <= '0;
            prg_swap_reg    <= 1'b0;
            mirroring_reg   <= '0;
            irq_reload_reg  <= '0;
            irq_count_reg   <= '0;
            prescale_reg    <= PRESCALE_PERIOD;
            ack_enable_reg  <= 1'b0;
            irq_enabled_reg <= 1'b0;
            cycle_mode_reg  <= 1'b0;
            irq_pending_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_PRG_BANKS_LOG2: prg_log2_reg <= cfg_wdata[2:0];
                    CFG_CHR_BANKS_LOG2: chr_log2_reg <= cfg_wdata;
                    default:            prg_log2_reg <= prg_log2_reg;
                endcase
            end
            if (advance) begin
                prg_first_reg   <= prg_first_next;
                prg_second_reg  <= prg_second_next;
                prg_swap_reg    <= prg_swap_next;
                mirroring_reg   <= mirroring_next;
                irq_reload_reg  <= irq_reload_next;
                irq_count_reg   <= irq_count_next;
                prescale_reg    <= prescale_next;
                ack_enable_reg  <= ack_enable_next;
                irq_enabled_reg <= irq_enabled_next;
                cycle_mode_reg  <= cycle_mode_next;
                irq_pending_reg <= irq_pending_next;
            end
        end
    end

    // Pattern bank selects: low nibble and high five bits written separately.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < CHR_SLOTS; i++) begin
                chr_sel_reg[i] <= '0;
            end
        end else if (chr_wr) begin
            if (addr_lo[0]) begin
                chr_sel_reg[chr_wr_slot][8:4] <= in_data_reg[4:0];
            end else begin
                chr_sel_reg[chr_wr_slot][3:0] <= in_data_reg[3:0];
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (in_xfer) begin
            in_cmd_reg  <= s_command;
            in_addr_reg <= s_address;
            in_data_reg <= s_write_data;
        end
        if (advance) begin
            out_irq_reg    <= out_irq_next;
            out_map_reg    <= out_map_next;
            out_mirror_reg <= out_mirror_next;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_irq_line       = out_irq_reg;
    assign m_mapped_address = out_map_reg;
    assign m_nt_mirror      = out_mirror_reg;

    // The interrupt is raised only by a tick transfer.
    a_irq_from_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(irq_pending_reg) |-> $past(advance && (in_cmd_reg == CMD_TICK)))
        else $error("irq pending set without a tick");

    // A write to any timer register clears the pending interrupt.
    a_irq_write_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && (in_cmd_reg == CMD_WRITE) && addr_exact && (addr_hi == HI_IRQ))
        |=> !irq_pending_reg)
        else $error("timer register write left irq pending");

    // The prescaler stays within one period and never rests at zero.
    a_prescale_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (prescale_reg != 9'd0) && (prescale_reg <= PRESCALE_PERIOD))
        else $error("prescaler out of range");

endmodule

// ===== tb/sv/bank_switch_mapper_with_irq_timer_tb.sv =====
`timescale 1ns / 1ps

module bank_switch_mapper_with_irq_timer_tb;
    import bsm_pkg::*;

    localparam int DRAIN_CYCLES = 8;   // result path is two registers deep; leave slack

    // One result transfer as the block presents it
    typedef struct packed {
        logic                irq;
        logic [MAP_W-1:0]    mapped;
        logic [MIRROR_W-1:0] mirror;
    } mapper_result_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_command;
    logic [ADDR_W-1:0]     s_address;
    logic [DATA_W-1:0]     s_write_data;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_irq_line;
    logic [MAP_W-1:0]      m_mapped_address;
    logic [MIRROR_W-1:0]   m_nt_mirror;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    bank_switch_mapper_with_irq_timer DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_address        (s_address),
        .s_write_data     (s_write_data),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_irq_line       (m_irq_line),
        .m_mapped_address (m_mapped_address),
        .m_nt_mirror      (m_nt_mirror),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata)
    );

    // Mapper state mirrored on the testbench side
    logic [4:0]  prg_first_sel;
    logic [4:0]  prg_second_sel;
    logic        prg_swap_mode;
    logic [1:0]  mirror_sel;
    chr_sel_t    chr_slot_sel [CHR_SLOTS];
    logic [7:0]  irq_latch;
    logic [7:0]  irq_counter;
    int          prescale_left;
    logic        ack_reenable;
    logic        irq_armed;
    logic        cycle_count_mode;
    logic        irq_flag;
    logic [2:0]  prg_size_log2;
    logic [3:0]  chr_size_log2;

    mapper_result_t expected_results[$];
    int             mismatches;
    int             items_sent;
    bit             src_gaps;
    bit             sink_stalls;

    always #5 aclk = ~aclk;

    // Advance the interrupt counter by one count; wrap from the top reloads and raises IRQ.
    function automatic void count_up();
        if (irq_counter == COUNT_TOP) begin
            irq_counter = irq_latch;
            irq_flag    = 1'b1;
        end else begin
            irq_counter = irq_counter + 8'd1;
        end
    endfunction

    // Apply one command to the mirrored state and return the result it must produce.
    function automatic mapper_result_t apply_command(input logic [CMD_W-1:0] cmd,
                                                     input logic [ADDR_W-1:0] addr,
                                                     input logic [DATA_W-1:0] data);
        mapper_result_t r;
        logic [3:0]     hi;
        logic [11:0]    lo;
        logic [3:0]     chr_off;
        logic [2:0]     slot;
        logic [2:0]     prg_lg;
        logic [4:0]     prg_mask;
        logic [4:0]     bank;
        logic [3:0]     chr_lg;
        logic [8:0]     chr_mask;
        hi       = addr[15:12];
        lo       = addr[11:0];
        r.mapped = '0;
        case (cmd)
            CMD_WRITE: begin
                // only the four lowest offsets of each 4 KiB page decode
                if (lo <= 12'd3) begin
                    if (hi == HI_PRG_FIRST) begin
                        prg_first_sel = data[4:0];
                    end else if (hi == HI_MIRROR) begin
                        if (!lo[1]) mirror_sel = data[1:0];
                        else        prg_swap_mode = data[1];
                    end else if (hi == HI_PRG_SECOND) begin
                        prg_second_sel = data[4:0];
                    end else if (hi >= HI_CHR_FIRST && hi <= HI_CHR_LAST) begin
                        chr_off = hi - HI_CHR_FIRST;
                        slot    = {chr_off[1:0], lo[1]};
                        if (lo[0]) chr_slot_sel[slot][8:4] = data[4:0];
                        else       chr_slot_sel[slot][3:0] = data[3:0];
                    end else if (hi == HI_IRQ) begin
                        irq_flag = 1'b0;
                        case (lo[1:0])
                            IRQ_LATCH_LO: irq_latch[3:0] = data[3:0];
                            IRQ_LATCH_HI: irq_latch[7:4] = data[3:0];
                            IRQ_CONTROL: begin
                                ack_reenable     = data[0];
                                irq_armed        = data[1];
                                cycle_count_mode = data[2];
                                if (data[1]) begin
                                    irq_counter   = irq_latch;
                                    prescale_left = int'(PRESCALE_PERIOD);
                                end
                            end
                            IRQ_ACK: irq_armed = ack_reenable;
                            default: irq_armed = irq_armed;
                        endcase
                    end
                end
            end
            CMD_TICK: begin
                if (irq_armed) begin
                    if (cycle_count_mode) begin
                        count_up();
                    end else begin
                        prescale_left = prescale_left - int'(PRESCALE_STEP);
                        if (prescale_left <= 0) begin
                            prescale_left = prescale_left + int'(PRESCALE_PERIOD);
                            count_up();
                        end
                    end
                end
            end
            CMD_PRG: begin
                // nothing below the cartridge ROM window maps
                if (addr[15]) begin
                    prg_lg = (prg_size_log2 < PRG_LOG2_MIN) ? PRG_LOG2_MIN :
                             (prg_size_log2 > PRG_LOG2_MAX) ? PRG_LOG2_MAX : prg_size_log2;
                    prg_mask = 5'((6'd1 << prg_lg) - 6'd1);
                    case (addr[14:13])
                        2'd0:    bank = prg_swap_mode ? prg_mask - 5'd1 : prg_first_sel;
                        2'd1:    bank = prg_second_sel;
                        2'd2:    bank = prg_swap_mode ? prg_first_sel : prg_mask - 5'd1;
                        default: bank = prg_mask;
                    endcase
                    r.mapped = {1'b0, bank & prg_mask, addr[12:0]};
                end
            end
            default: begin
                chr_lg   = (chr_size_log2 > CHR_LOG2_MAX) ? CHR_LOG2_MAX : chr_size_log2;
                chr_mask = 9'((10'd1 << chr_lg) - 10'd1);
                r.mapped = {chr_slot_sel[addr[12:10]] & chr_mask, addr[9:0]};
            end
        endcase
        r.irq    = irq_flag;
        r.mirror = mirror_sel;
        return r;
    endfunction

    // Present one item, hold it until the transfer, then record what it must return.
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                             input logic [DATA_W-1:0] data);
        int gap;
        gap = (src_gaps && $urandom_range(0, 4) == 0) ? $urandom_range(1, 9) : 0;
        if (gap > 0) begin
            @(negedge aclk);
            s_valid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        @(negedge aclk);
        s_valid      = 1'b1;
        s_command    = cmd;
        s_address    = addr;
        s_write_data = data;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        expected_results.push_back(apply_command(cmd, addr, data));
        items_sent++;
    endtask

    // Drop valid and let every outstanding result drain out of the pipe.
    task automatic wait_for_idle();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // Write one size register; only ever done with the pipe empty.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        wait_for_idle();
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        if (idx == CFG_PRG_BANKS_LOG2)      prg_size_log2 = value[2:0];
        else if (idx == CFG_CHR_BANKS_LOG2) chr_size_log2 = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // Translations straight out of reset, including an address below the ROM window.
    task automatic test_power_on_translation();
        send_item(CMD_PRG, 16'h8000, 8'h00);
        send_item(CMD_PRG, 16'hFFFF, 8'hFF);
        send_item(CMD_PRG, 16'h0000, 8'h00);
        send_item(CMD_CHR, 16'h1FFF, 8'h00);
    endtask

    // Each kind of bank register, unmapped offsets, swap mode and an oversized CHR address.
    task automatic test_bank_registers();
        send_item(CMD_WRITE, 16'h8000, 8'hFF);
        send_item(CMD_WRITE, 16'h9000, 8'h03);
        send_item(CMD_WRITE, 16'h9002, 8'hFF);
        send_item(CMD_WRITE, 16'hA003, 8'h1F);
        send_item(CMD_WRITE, 16'hB000, 8'hFF);
        send_item(CMD_WRITE, 16'hB001, 8'hFF);
        send_item(CMD_WRITE, 16'hE003, 8'h00);
        // offsets past the decoded four must leave everything alone
        send_item(CMD_WRITE, 16'h8004, 8'h00);
        send_item(CMD_WRITE, 16'hFFFF, 8'h00);
        send_item(CMD_PRG, 16'h8000, 8'h00);
        send_item(CMD_PRG, 16'hA000, 8'h00);
        send_item(CMD_PRG, 16'hC000, 8'h00);
        send_item(CMD_PRG, 16'hFFFF, 8'h00);
        send_item(CMD_CHR, 16'hFFFF, 8'h00);
        send_item(CMD_CHR, 16'h0000, 8'h00);
    endtask

    // Cycle-mode count through the top, then acknowledge with re-enable.
    task automatic test_irq_counter();
        send_item(CMD_WRITE, 16'hF000, 8'h0E);
        send_item(CMD_WRITE, 16'hF001, 8'h0F);
        send_item(CMD_WRITE, 16'hF002, 8'h07);
        send_item(CMD_TICK, 16'h0000, 8'h00);
        send_item(CMD_TICK, 16'h0000, 8'h00);
        send_item(CMD_WRITE, 16'hF003, 8'h00);
        send_item(CMD_TICK, 16'h0000, 8'h00);
    endtask

    // Phases of random traffic, each under its own bank size setting.
    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] prg_v;
        logic [CFG_DATA_W-1:0] chr_v;
        logic [ADDR_W-1:0]     addr;
        logic [DATA_W-1:0]     data;
        logic [CMD_W-1:0]      cmd;
        logic [3:0]            hi;
        int                    phase_end;
        int                    n;
        int                    pick;
        for (int phase = 0; phase < 12; phase++) begin
            // hit the saturation points first, then random sizes
            case (phase)
                0:       begin prg_v = 4'd0;  chr_v = 4'd0;  end
                1:       begin prg_v = 4'd15; chr_v = 4'd15; end
                2:       begin prg_v = 4'd1;  chr_v = 4'd9;  end
                3:       begin prg_v = 4'd5;  chr_v = 4'd10; end
                4:       begin prg_v = 4'd8;  chr_v = 4'd8;  end
                default: begin
                    prg_v = 4'($urandom_range(0, 15));
                    chr_v = 4'($urandom_range(0, 15));
                end
            endcase
            cfg_write(CFG_PRG_BANKS_LOG2, prg_v);
            cfg_write(CFG_CHR_BANKS_LOG2, chr_v);
            // every third phase runs flat out; the closing phases never idle
            src_gaps    = (phase < 10) && (phase % 3 != 0);
            sink_stalls = src_gaps;
            phase_end   = items_sent + 100;
            while (items_sent < phase_end) begin
                pick = $urandom_range(0, 9);
                if (pick <= 3) begin
                    // bank setup followed by lookups through it
                    n = $urandom_range(1, 4);
                    repeat (n) begin
                        case ($urandom_range(0, 6))
                            0:       hi = HI_PRG_FIRST;
                            1:       hi = HI_MIRROR;
                            2:       hi = HI_PRG_SECOND;
                            default: hi = HI_CHR_FIRST + 4'($urandom_range(0, 3));
                        endcase
                        addr = {hi, 10'd0, 2'($urandom_range(0, 3))};
                        send_item(CMD_WRITE, addr, 8'($urandom_range(0, 255)));
                    end
                    n = $urandom_range(2, 6);
                    repeat (n) begin
                        cmd  = $urandom_range(0, 1) ? CMD_PRG : CMD_CHR;
                        addr = 16'($urandom_range(0, 65535));
                        if ($urandom_range(0, 7) != 0) begin
                            if (cmd == CMD_PRG) addr[15] = 1'b1;
                            else                addr[15:13] = 3'd0;
                        end
                        send_item(cmd, addr, 8'($urandom_range(0, 255)));
                    end
                end else if (pick <= 6) begin
                    // timer run: latch biased near the top so the wrap comes soon
                    data = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 1)) data[3:0] = 4'hF - 4'($urandom_range(0, 2));
                    send_item(CMD_WRITE, {HI_IRQ, 10'd0, IRQ_LATCH_LO}, data);
                    data = 8'($urandom_range(0, 255));
                    if ($urandom_range(0, 2) != 0) data[3:0] = 4'hF;
                    send_item(CMD_WRITE, {HI_IRQ, 10'd0, IRQ_LATCH_HI}, data);
                    data    = 8'($urandom_range(0, 255));
                    data[1] = ($urandom_range(0, 3) != 0);
                    send_item(CMD_WRITE, {HI_IRQ, 10'd0, IRQ_CONTROL}, data);
                    if (data[2])                       n = $urandom_range(1, 12);
                    else if ($urandom_range(0, 3) == 0) n = $urandom_range(100, 240);
                    else                               n = $urandom_range(1, 20);
                    repeat (n) begin
                        pick = $urandom_range(0, 15);
                        if (pick == 0)
                            send_item(CMD_WRITE, {HI_IRQ, 10'd0, IRQ_ACK},
                                      8'($urandom_range(0, 255)));
                        else if (pick == 1)
                            send_item(CMD_CHR, 16'($urandom_range(0, 8191)),
                                      8'($urandom_range(0, 255)));
                        else
                            send_item(CMD_TICK, 16'($urandom_range(0, 65535)),
                                      8'($urandom_range(0, 255)));
                    end
                end else if (pick <= 8) begin
                    n = $urandom_range(1, 8);
                    repeat (n)
                        send_item($urandom_range(0, 1) ? CMD_PRG : CMD_CHR,
                                  16'($urandom_range(0, 65535)), 8'($urandom_range(0, 255)));
                end else begin
                    // raw noise: random commands, and writes that mostly miss the decoded offsets
                    n = $urandom_range(1, 4);
                    repeat (n)
                        send_item(2'($urandom_range(0, 3)), 16'($urandom_range(0, 65535)),
                                  8'($urandom_range(0, 255)));
                end
            end
        end
    endtask

    // Result side: stall in random bursts while stalls are on.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (sink_stalls && $urandom_range(0, 4) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(0, 8)) @(negedge aclk);
            end else begin
                m_ready = 1'b1;
            end
        end
    end

    // Compare each result transfer against the oldest outstanding expectation.
    always @(posedge aclk) begin : result_check
        mapper_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatches++;
                $display("%0t: result expected none actual irq=%0b addr=%05h mirror=%0d",
                         $time, m_irq_line, m_mapped_address, m_nt_mirror);
            end else begin
                want = expected_results.pop_front();
                if (m_irq_line !== want.irq) begin
                    mismatches++;
                    $display("%0t: irq_line expected %0b actual %0b", $time,
                             want.irq, m_irq_line);
                end
                if (m_mapped_address !== want.mapped) begin
                    mismatches++;
                    $display("%0t: mapped_address expected %05h actual %05h", $time,
                             want.mapped, m_mapped_address);
                end
                if (m_nt_mirror !== want.mirror) begin
                    mismatches++;
                    $display("%0t: nt_mirror expected %0d actual %0d", $time,
                             want.mirror, m_nt_mirror);
                end
            end
        end
    end

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_command    = CMD_WRITE;
        s_address    = '0;
        s_write_data = '0;
        cfg_wr_en    = 1'b0;
        cfg_index    = CFG_PRG_BANKS_LOG2;
        cfg_wdata    = '0;
        src_gaps     = 1'b0;
        sink_stalls  = 1'b0;
        mismatches   = 0;
        items_sent   = 0;

        // power-on state of the mirrored mapper
        prg_first_sel    = '0;
        prg_second_sel   = '0;
        prg_swap_mode    = 1'b0;
        mirror_sel       = '0;
        foreach (chr_slot_sel[i]) chr_slot_sel[i] = '0;
        irq_latch        = '0;
        irq_counter      = '0;
        prescale_left    = int'(PRESCALE_PERIOD);
        ack_reenable     = 1'b0;
        irq_armed        = 1'b0;
        cycle_count_mode = 1'b0;
        irq_flag         = 1'b0;
        prg_size_log2    = PRG_LOG2_RESET;
        chr_size_log2    = CHR_LOG2_RESET;

        repeat (2) @(negedge aclk);
        aresetn = 1'b1;

        test_power_on_translation();
        test_bank_registers();
        test_irq_counter();
        test_random_traffic();

        wait_for_idle();
        if (mismatches == 0)
            $display("bank_switch_mapper_with_irq_timer_tb: clean");
        else
            $display("bank_switch_mapper_with_irq_timer_tb: errors");
        $finish;
    end

    // Hang guard: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("bank_switch_mapper_with_irq_timer_tb: errors");
        $finish;
    end

endmodule

// ===== bank_switch_mapper_with_irq_timer.f =====
rtl/bsm_pkg.sv
rtl/bank_switch_mapper_with_irq_timer.sv
tb/sv/bank_switch_mapper_with_irq_timer_tb.sv
